>>> hw/rtl/hca_pkg.sv
// shared types and constants of the hit channel adjacency block
`default_nettype none

package hca_pkg;

    localparam int MAX_HITS_DEF     = 64;
    localparam int CHANNEL_BITS_DEF = 20;
    localparam int HIT_CHANNEL_W    = 20;
    localparam int TOL_BITS         = 8;
    localparam int TOL_W            = TOL_BITS + 1;
    localparam int ADJ_BITS         = 7;
    localparam int ADJ_MAX          = 127;
    localparam int GAP_SMALL        = 2;
    localparam int GAP_LARGE        = 3;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctrl_t;

    typedef struct packed {
        logic load_first;
        logic step_pair;
        logic final_pair;
    } scan_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hca_cell.sv
// one cell of the sorting chain: holds a channel, inserts in order, shifts out toward cell 0
`default_nettype none

module hca_cell #(
    parameter int CHANNEL_BITS = hca_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hca_pkg::chain_ctrl_t    ctrl,
    input  wire logic [CHANNEL_BITS-1:0] new_val,
    input  wire logic [CHANNEL_BITS-1:0] left_val,
    input  wire logic                    left_vld,
    input  wire logic                    left_gt,
    input  wire logic [CHANNEL_BITS-1:0] right_val,
    output logic [CHANNEL_BITS-1:0]      val,
    output logic                         vld,
    output logic                         gt
);

    logic [CHANNEL_BITS-1:0] val_reg;
    logic [CHANNEL_BITS-1:0] val_next;
    logic                    vld_reg;
    logic                    vld_next;

    assign gt = vld_reg && (val_reg > new_val);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.clear)
        begin
            vld_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            val_next = right_val;
        end
        else if (ctrl.insert && (!vld_reg || gt))
        begin
            if (left_gt)
            begin
                val_next = left_val;
                vld_next = 1'b1;
            end
            else if (left_vld)
            begin
                val_next = new_val;
                vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hca_scan.sv
// scan unit: walks the drained sorted list pair by pair and tracks the longest run
`default_nettype none

module hca_scan #(
    parameter int MAX_HITS     = hca_pkg::MAX_HITS_DEF,
    parameter int CHANNEL_BITS = hca_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hca_pkg::scan_ctrl_t           ctrl,
    input  wire logic [CHANNEL_BITS-1:0]       head,
    input  wire logic [hca_pkg::TOL_BITS-1:0]  gap_tolerance,
    output logic [hca_pkg::ADJ_BITS-1:0]       best_sat
);

    localparam int RUN_W = $clog2(MAX_HITS + 2);
    localparam int EXT_W = CHANNEL_BITS + 2;

    logic [CHANNEL_BITS-1:0]   first_reg;
    logic [CHANNEL_BITS-1:0]   prev_reg;
    logic [RUN_W-1:0]          run_reg;
    logic [RUN_W-1:0]          run_next;
    logic [RUN_W-1:0]          best_reg;
    logic [RUN_W-1:0]          best_next;
    logic [hca_pkg::TOL_W-1:0] tol_reg;
    logic [hca_pkg::TOL_W-1:0] tol_next;

    logic [CHANNEL_BITS-1:0]   nxt;
    logic [EXT_W-1:0]          cur_ext;
    logic [EXT_W-1:0]          nxt_ext;
    logic                      is_zero;
    logic                      is_eq;
    logic                      is_one;
    logic                      is_two;
    logic                      is_three;
    logic                      tol_ok;
    logic                      end_run;
    logic                      extend;

    assign nxt      = ctrl.final_pair ? first_reg : head;
    assign cur_ext  = {2'b00, prev_reg};
    assign nxt_ext  = {2'b00, nxt};
    assign is_zero  = (nxt == '0);
    assign is_eq    = (nxt == prev_reg);
    assign is_one   = (nxt_ext == cur_ext + EXT_W'(1));
    assign is_two   = (nxt_ext == cur_ext + EXT_W'(hca_pkg::GAP_SMALL));
    assign is_three = (nxt_ext == cur_ext + EXT_W'(hca_pkg::GAP_LARGE));
    assign tol_ok   = (tol_reg < {1'b0, gap_tolerance});

    always_comb
    begin
        end_run = 1'b0;
        extend  = 1'b0;
        priority if (is_zero)
        begin
            end_run = 1'b1;
        end
        else if (is_eq)
        begin
            end_run = 1'b0;
        end
        else if (is_one || ((is_two || is_three) && tol_ok))
        begin
            extend = 1'b1;
        end
        else
        begin
            end_run = 1'b1;
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        tol_next  = tol_reg;
        best_next = best_reg;
        if (ctrl.load_first)
        begin
            run_next  = RUN_W'(1);
            tol_next  = '0;
            best_next = '0;
        end
        else if (ctrl.step_pair || ctrl.final_pair)
        begin
            if (end_run)
            begin
                if (run_reg > best_reg)
                begin
                    best_next = run_reg;
                end
                run_next = RUN_W'(1);
                tol_next = '0;
            end
            else if (extend)
            begin
                run_next = run_reg + RUN_W'(1);
                if (!is_one)
                begin
                    tol_next = tol_reg + (is_two ? hca_pkg::TOL_W'(hca_pkg::GAP_SMALL)
                                                 : hca_pkg::TOL_W'(hca_pkg::GAP_LARGE));
                end
            end
        end
    end

    generate
        if (RUN_W > hca_pkg::ADJ_BITS)
        begin : g_sat
            assign best_sat = (best_next > RUN_W'(hca_pkg::ADJ_MAX))
                            ? hca_pkg::ADJ_BITS'(hca_pkg::ADJ_MAX)
                            : best_next[hca_pkg::ADJ_BITS-1:0];
        end
        else
        begin : g_ext
            assign best_sat = hca_pkg::ADJ_BITS'(best_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= RUN_W'(1);
            tol_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            tol_reg  <= tol_next;
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_first)
        begin
            first_reg <= head;
        end
        if (ctrl.load_first || ctrl.step_pair)
        begin
            prev_reg <= head;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hit_channel_adjacency_core.sv
// top level: sorting cell chain, drain and scan sequencer, result register
// hits go into the insertion chain at one beat per cycle while collecting (busy low)
// a beat with last_hit starts the drain: busy stays high while each stored hit is shifted
// from the chain into the scan unit and through the final wrap-around compare
// done pulses for one cycle in the cycle busy falls; the receiver cannot stall
// rst_n is asynchronous: clears the chain valid bits, hit count, overflow flag and gap_tolerance
`default_nettype none

module hit_channel_adjacency_core #(
    parameter int MAX_HITS     = hca_pkg::MAX_HITS_DEF,
    parameter int CHANNEL_BITS = hca_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [hca_pkg::HIT_CHANNEL_W-1:0]   hit_channel,
    input  wire logic                                last_hit,
    input  wire logic                                cfg_write,
    input  wire logic [hca_pkg::TOL_BITS-1:0]        cfg_data,
    output logic                                     done,
    output logic [hca_pkg::ADJ_BITS-1:0]             max_adjacency,
    output logic                                     overflowed
);

    localparam int CNT_W = $clog2(MAX_HITS + 1);

    hca_pkg::state_t              state_reg;
    hca_pkg::state_t              state_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             k_reg;
    logic [CNT_W-1:0]             k_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [hca_pkg::TOL_BITS-1:0] tol_cfg_reg;
    logic                         done_reg;
    logic [hca_pkg::ADJ_BITS-1:0] max_reg;
    logic                         ovf_out_reg;

    logic                         accept;
    logic                         room;
    hca_pkg::chain_ctrl_t         chain_ctrl;
    hca_pkg::scan_ctrl_t          scan_ctrl;
    logic [CHANNEL_BITS-1:0]      ch_in;
    logic [hca_pkg::ADJ_BITS-1:0] best_sat;

    logic [CHANNEL_BITS-1:0]      cell_val [MAX_HITS];
    logic                         cell_vld [MAX_HITS];
    logic                         cell_gt  [MAX_HITS];

    generate
        if (CHANNEL_BITS <= hca_pkg::HIT_CHANNEL_W)
        begin : g_trunc
            assign ch_in = hit_channel[CHANNEL_BITS-1:0];
        end
        else
        begin : g_zext
            assign ch_in = {{(CHANNEL_BITS - hca_pkg::HIT_CHANNEL_W){1'b0}}, hit_channel};
        end
    endgenerate

    assign busy   = (state_reg != hca_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign room   = (count_reg < CNT_W'(MAX_HITS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hca_pkg::ST_IDLE:
            begin
                if (accept && last_hit)
                begin
                    state_next = hca_pkg::ST_SCAN;
                end
            end
            hca_pkg::ST_SCAN:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = hca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hca_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        chain_ctrl = '0;
        scan_ctrl  = '0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        unique case (state_reg)
            hca_pkg::ST_IDLE:
            begin
                k_next = '0;
                if (accept)
                begin
                    if (room)
                    begin
                        chain_ctrl.insert = 1'b1;
                        count_next        = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            hca_pkg::ST_SCAN:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg == count_reg)
                begin
                    scan_ctrl.final_pair = 1'b1;
                    chain_ctrl.clear     = 1'b1;
                    count_next           = '0;
                    ovf_next             = 1'b0;
                end
                else if (k_reg == '0)
                begin
                    scan_ctrl.load_first = 1'b1;
                    chain_ctrl.shift     = 1'b1;
                end
                else
                begin
                    scan_ctrl.step_pair = 1'b1;
                    chain_ctrl.shift    = 1'b1;
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    generate
        for (genvar i = 0; i < MAX_HITS; i++)
        begin : g_chain
            logic [CHANNEL_BITS-1:0] lval;
            logic                    lvld;
            logic                    lgt;
            logic [CHANNEL_BITS-1:0] rval;

            if (i == 0)
            begin : g_head
                assign lval = '0;
                assign lvld = 1'b1;
                assign lgt  = 1'b0;
            end
            else
            begin : g_body
                assign lval = cell_val[i-1];
                assign lvld = cell_vld[i-1];
                assign lgt  = cell_gt[i-1];
            end

            if (i == MAX_HITS - 1)
            begin : g_tail
                assign rval = '0;
            end
            else
            begin : g_mid
                assign rval = cell_val[i+1];
            end

            hca_cell #(
                .CHANNEL_BITS (CHANNEL_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (chain_ctrl),
                .new_val   (ch_in),
                .left_val  (lval),
                .left_vld  (lvld),
                .left_gt   (lgt),
                .right_val (rval),
                .val       (cell_val[i]),
                .vld       (cell_vld[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    hca_scan #(
        .MAX_HITS     (MAX_HITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (scan_ctrl),
        .head          (cell_val[0]),
        .gap_tolerance (tol_cfg_reg),
        .best_sat      (best_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hca_pkg::ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            ovf_reg     <= 1'b0;
            tol_cfg_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            done_reg  <= scan_ctrl.final_pair;
            if (cfg_write)
            begin
                tol_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_ctrl.final_pair)
        begin
            max_reg     <= best_sat;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign done          = done_reg;
    assign max_adjacency = max_reg;
    assign overflowed    = ovf_out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hca_checker.sv
// port-level checker for the adjacency core and its bind
`default_nettype none

module hca_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_hit,
    input wire logic done
);

    // closing beat starts the scan
    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_hit) |=> busy)
        else $error("busy not raised after closing beat");

    // a result only follows a scan
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding scan");

    // end of scan always delivers exactly one result
    a_fall_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind hit_channel_adjacency_core hca_checker u_hca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .last_hit (last_hit),
    .done     (done)
);

`default_nettype wire

>>> sim/hit_channel_adjacency_core_tb.sv
// testbench for hit_channel_adjacency_core: directed and random hit windows checked against a sorting predictor
module hit_channel_adjacency_core_tb;

    localparam int CH_W    = hca_pkg::HIT_CHANNEL_W;
    localparam int ADJ_W   = hca_pkg::ADJ_BITS;
    localparam int TOL_W   = hca_pkg::TOL_BITS;
    localparam int HITS    = hca_pkg::MAX_HITS_DEF;
    localparam int REPORTS = 10;

    typedef struct packed {
        logic [ADJ_W-1:0] adj;
        logic             ovf;
    } window_result_t;

    class adjacency_scoreboard;
        logic [CH_W-1:0]  window_q[$];
        bit               dropped;
        bit [TOL_W-1:0]   tolerance;
        window_result_t   expected_q[$];
        int               mismatches;

        function void set_tolerance(bit [TOL_W-1:0] value);
            tolerance = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int longest_run();
            int n;
            int run;
            int best;
            int tol;
            int cur;
            int nxt;
            bit end_run;
            n = window_q.size();
            run = 1;
            best = 0;
            tol = 0;
            for (int i = 0; i < n; i++)
            begin
                cur = int'(window_q[i]);
                nxt = int'(window_q[(i + 1 == n) ? 0 : i + 1]);
                if (nxt == 0)
                    end_run = 1'b1;
                else if (nxt == cur)
                    continue;
                else if (nxt == cur + 1)
                begin
                    run++;
                    end_run = 1'b0;
                end
                else if ((nxt == cur + hca_pkg::GAP_SMALL || nxt == cur + hca_pkg::GAP_LARGE)
                         && tol < int'(tolerance))
                begin
                    run++;
                    tol += nxt - cur;
                    end_run = 1'b0;
                end
                else
                    end_run = 1'b1;
                if (end_run)
                begin
                    if (run > best)
                        best = run;
                    run = 1;
                    tol = 0;
                end
            end
            return (best > hca_pkg::ADJ_MAX) ? hca_pkg::ADJ_MAX : best;
        endfunction

        function void note_hit(logic [CH_W-1:0] ch, logic lst);
            window_result_t r;
            int pos;
            if (window_q.size() < HITS)
            begin
                pos = window_q.size();
                while (pos > 0 && window_q[pos-1] > ch)
                    pos--;
                window_q.insert(pos, ch);
            end
            else
                dropped = 1'b1;
            if (lst)
            begin
                r.adj = ADJ_W'(longest_run());
                r.ovf = dropped;
                expected_q.insert(expected_q.size(), r);
                window_q.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [ADJ_W-1:0] adj, logic ovf);
            window_result_t r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORTS)
                    $display("unexpected result: max_adjacency %0d overflowed %0d", adj, ovf);
                return;
            end
            r = expected_q.pop_front();
            if (r.adj !== adj || r.ovf !== ovf)
            begin
                mismatches++;
                if (mismatches <= REPORTS)
                    $display("mismatch at %0t: expected max_adjacency %0d overflowed %0d, got %0d %0d",
                             $realtime, r.adj, r.ovf, adj, ovf);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CH_W-1:0]   hit_channel;
    logic              last_hit;
    logic              cfg_write;
    logic [TOL_W-1:0]  cfg_data;
    logic              done;
    logic [ADJ_W-1:0]  max_adjacency;
    logic              overflowed;

    adjacency_scoreboard sb = new();
    logic [CH_W-1:0]     hit_q[$];
    int                  idle_pct;
    int                  items_sent;

    hit_channel_adjacency_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .hit_channel   (hit_channel),
        .last_hit      (last_hit),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .done          (done),
        .max_adjacency (max_adjacency),
        .overflowed    (overflowed)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(max_adjacency, overflowed);
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_hit(input logic [CH_W-1:0] ch, input logic lst);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        hit_channel = ch;
        last_hit = lst;
        do
            @(posedge clk);
        while (busy);
        sb.note_hit(ch, lst);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_window();
        for (int i = 0; i < hit_q.size(); i++)
            send_hit(hit_q[i], i == hit_q.size() - 1);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (HITS + 8) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_write = 1'b1;
        cfg_data = value;
        sb.set_tolerance(value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [CH_W-1:0] next_stride();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return '0;
        if (p < 55)
            return CH_W'(1);
        if (p < 70)
            return CH_W'(2);
        if (p < 85)
            return CH_W'(3);
        if (p < 95)
            return CH_W'($urandom_range(4, 6));
        return CH_W'($urandom_range(7, 5000));
    endfunction

    task automatic send_random_window();
        int n;
        int pick;
        int j;
        bit noisy;
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] tmp;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            n = $urandom_range(HITS - 4, HITS + 6);
        else if (pick < 12)
            n = $urandom_range(13, 40);
        else
            n = $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ch = '0;
        else if (pick < 20)
            ch = {CH_W{1'b1}} - CH_W'($urandom_range(0, 40));
        else
            ch = CH_W'($urandom);
        noisy = ($urandom_range(0, 99) < 20);
        hit_q.delete();
        for (int k = 0; k < n; k++)
        begin
            hit_q.insert(hit_q.size(), ch);
            ch = noisy ? CH_W'($urandom) : ch + next_stride();
        end
        // arrival order: shuffled, ascending or descending
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            for (int k = n - 1; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                tmp = hit_q[k];
                hit_q[k] = hit_q[j];
                hit_q[j] = tmp;
            end
        end
        else if (pick >= 80)
        begin
            for (int k = 0; k < n / 2; k++)
            begin
                tmp = hit_q[k];
                hit_q[k] = hit_q[n-1-k];
                hit_q[n-1-k] = tmp;
            end
        end
        send_window();
    endtask

    initial
    begin
        int tol_plan[6];
        int goal;
        tol_plan = '{0, 255, 1, 4, 2, 0};
        rst_n = 1'b0;
        start = 1'b0;
        hit_channel = '0;
        last_hit = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // tolerance still at its reset value
        hit_q = '{20'd22, 20'd20, 20'd23};
        send_window();
        wait_drained();
        write_tolerance(TOL_W'(3));
        hit_q = '{20'd0};
        send_window();
        hit_q = '{20'hFFFFF};
        send_window();
        hit_q = '{20'd7, 20'd7, 20'd7};
        send_window();
        hit_q = '{20'd0, 20'd0};
        send_window();
        // gaps of two and three inside one run
        hit_q = '{20'd16, 20'd10, 20'd13, 20'd17, 20'd11};
        send_window();
        hit_q = '{20'd40, 20'd44, 20'd0};
        send_window();
        hit_q = '{20'hFFFFE, 20'd1, 20'hFFFFF};
        send_window();

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_tolerance((ph == 5) ? TOL_W'($urandom_range(0, 255)) : TOL_W'(tol_plan[ph]));
            idle_pct = (ph < 2) ? 32 : (ph < 4) ? 53 : 0;
            goal = items_sent + 313;
            while (items_sent < goal)
                send_random_window();
        end
        wait_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("hit_channel_adjacency_core verification clean");
        else
            $display("hit_channel_adjacency_core verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("hit_channel_adjacency_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hca_pkg.sv
hw/rtl/hca_cell.sv
hw/rtl/hca_scan.sv
hw/rtl/hit_channel_adjacency_core.sv
hw/rtl/hca_checker.sv
sim/hit_channel_adjacency_core_tb.sv
